[rtl/idalloc_pkg.sv]
// Shared types, codes and helpers for the identifier allocator.
// Used by idalloc_stack and id_allocator_with_recycle_stack; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package idalloc_pkg;

  localparam int unsigned IdW         = 8;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned StackDepth  = 1 << IdW;
  localparam int unsigned CountW      = IdW + 1;
  localparam int unsigned MaxIdDefault = 255;

  // Command codes, carried in tuser.
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK         = 2'd0;
  localparam logic [StatusW-1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_IN_USE = 2'd2;

  // Lowest and highest reserved ids above zero.
  localparam logic [IdW-1:0] RSV_LO = 8'd3;
  localparam logic [IdW-1:0] RSV_HI = 8'd8;

  typedef struct packed {
    logic           push;
    logic           pop;
    logic [IdW-1:0] push_id;
  } stk_req_t;

  typedef struct packed {
    logic           empty;
    logic [IdW-1:0] rd_id;
    logic           on_stack;
  } stk_sts_t;

  function automatic logic is_reserved(input logic [IdW-1:0] v);
    is_reserved = (v == '0) || ((v >= RSV_LO) && (v <= RSV_HI));
  endfunction

  function automatic logic is_valid(input logic [IdW-1:0] v, input logic [CountW-1:0] limit);
    is_valid = !is_reserved(v) && ({1'b0, v} <= limit);
  endfunction

endpackage

`default_nettype wire

[rtl/idalloc_stack.sv]
// Recycle stack of the identifier allocator: 256 x 8 memory, fill count and
// a membership bitmap that keeps duplicate pushes out. Depends on idalloc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idalloc_stack (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire idalloc_pkg::stk_req_t      req_i,
  input  wire logic [idalloc_pkg::IdW-1:0] query_id_i,
  output idalloc_pkg::stk_sts_t           sts_o
);
  import idalloc_pkg::*;

  logic [IdW-1:0]        mem [StackDepth];
  logic [IdW-1:0]        rd_q;
  logic [CountW-1:0]     count_q, count_d;
  logic [StackDepth-1:0] on_stack_q, on_stack_d;
  logic                  pop_pend_q;
  logic                  push_ok;
  logic [IdW-1:0]        top_idx;

  // The stack never holds duplicates, so it can never be full on a push.
  assign push_ok = req_i.push && !count_q[CountW-1];
  assign top_idx = count_q[IdW-1:0] - 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[count_q[IdW-1:0]] <= req_i.push_id;
    end
    if (req_i.pop) begin
      rd_q <= mem[top_idx];
    end
  end

  always_comb begin
    count_d    = count_q;
    on_stack_d = on_stack_q;
    if (push_ok) begin
      count_d                     = count_q + 1'b1;
      on_stack_d[req_i.push_id]   = 1'b1;
    end else if (req_i.pop) begin
      count_d = count_q - 1'b1;
    end
    // The popped entry leaves the stack once its data is out of the memory.
    if (pop_pend_q) begin
      on_stack_d[rd_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      on_stack_q <= '0;
      pop_pend_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      on_stack_q <= on_stack_d;
      pop_pend_q <= req_i.pop;
    end
  end

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.rd_id    = rd_q;
  assign sts_o.on_stack = on_stack_q[query_id_i];

endmodule

`default_nettype wire

[rtl/id_allocator_with_recycle_stack.sv]
// Top level of the identifier allocator with its sequencer and used map.
// Depends on idalloc_pkg and idalloc_stack.
`timescale 1ns / 1ps
`default_nettype none

// Grants ids from 1 to min(MAX_ID, 255); 0 and 3 to 8 are never granted.
// One beat in gives one beat out. The input is taken only while the
// sequencer is idle. A release, or an acquire whose preferred id is valid
// and free, goes from the input beat to the finish state and from there
// into the output register, and the input is ready again from then on.
// While a result still waits in the output register, the next one is held
// back and no input is taken. Otherwise the recycle stack is popped one
// entry at a time (one memory read per cycle) and, once the stack is empty,
// the next-id counter is tested one id per cycle. The used map is cleared
// at reset.
module id_allocator_with_recycle_stack #(
  parameter int unsigned MAX_ID = idalloc_pkg::MaxIdDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] id
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [7:0] granted_id, [9:8] status
);
  import idalloc_pkg::*;

  localparam logic [CountW-1:0] Limit = (MAX_ID > 255) ? 9'd255 : CountW'(MAX_ID);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0]            state_q, state_d;
  logic [StackDepth-1:0] used_q, used_d;
  logic [CountW-1:0]     next_id_q, next_id_d;
  logic [IdW-1:0]        res_id_q, res_id_d;
  logic [StatusW-1:0]    res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic [IdW-1:0]        out_id_q, out_id_d;
  logic [StatusW-1:0]    out_st_q, out_st_d;

  logic                  in_fire;
  logic [IdW-1:0]        in_id;
  logic                  in_cmd;
  logic [IdW-1:0]        cand;
  logic [IdW-1:0]        scan_id;
  stk_req_t              stk_req;
  stk_sts_t              stk_sts;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_id           = s_axis_tdata_i;
  assign in_cmd          = s_axis_tuser_i[0];
  assign cand            = stk_sts.rd_id;
  assign scan_id         = next_id_q[IdW-1:0];

  idalloc_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (stk_req),
    .query_id_i (in_id),
    .sts_o      (stk_sts)
  );

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    next_id_d   = next_id_q;
    res_id_d    = res_id_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_id_d    = out_id_q;
    out_st_d    = out_st_q;
    stk_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_ACQUIRE) begin
            if (is_valid(in_id, Limit) && !used_q[in_id]) begin
              used_d[in_id] = 1'b1;
              res_id_d      = in_id;
              res_st_d      = ST_OK;
              state_d       = S_FIN;
            end else if (!stk_sts.empty) begin
              stk_req.pop = 1'b1;
              state_d     = S_CHK;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            res_id_d = '0;
            state_d  = S_FIN;
            if (used_q[in_id]) begin
              used_d[in_id] = 1'b0;
              res_st_d      = ST_OK;
              if (is_valid(in_id, Limit) && !stk_sts.on_stack) begin
                stk_req.push    = 1'b1;
                stk_req.push_id = in_id;
              end
            end else begin
              res_st_d = ST_NOT_IN_USE;
            end
          end
        end
      end
      S_CHK: begin
        // Stale entries (invalid or already in use again) are dropped.
        if (is_valid(cand, Limit) && !used_q[cand]) begin
          used_d[cand] = 1'b1;
          res_id_d     = cand;
          res_st_d     = ST_OK;
          state_d      = S_FIN;
        end else if (!stk_sts.empty) begin
          stk_req.pop = 1'b1;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (next_id_q > Limit) begin
          res_id_d = '0;
          res_st_d = ST_EXHAUSTED;
          state_d  = S_FIN;
        end else if (is_reserved(scan_id) || used_q[scan_id]) begin
          next_id_d = next_id_q + 1'b1;
        end else begin
          used_d[scan_id] = 1'b1;
          next_id_d       = next_id_q + 1'b1;
          res_id_d        = scan_id;
          res_st_d        = ST_OK;
          state_d         = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_id_d    = res_id_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      next_id_q   <= CountW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    out_id_q <= out_id_d;
    out_st_q <= out_st_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_st_q, out_id_q};

endmodule

`default_nettype wire

[verif/idalloc_grant_checker.sv]
// Grant checker for the identifier allocator: watches both stream channels,
// predicts every result beat and compares it. Depends on idalloc_pkg.
`timescale 1ns / 1ps

module idalloc_grant_checker
  import idalloc_pkg::*;
#(
  parameter int unsigned MAX_ID = MaxIdDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] id
  input  logic [0:0]        s_axis_tuser_i,   // [0] command
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [15:0]       m_axis_tdata_i,   // [7:0] granted_id, [9:8] status
  output int                fail_count_o,
  output int                pending_o,
  output logic [255:0]      busy_ids_o,
  output int                grants_o,
  output int                exhausted_o,
  output int                refused_o
);

  localparam int unsigned IdLimit = (MAX_ID > 255) ? 255 : MAX_ID;

  typedef struct packed {
    logic [IdW-1:0]     granted;
    logic [StatusW-1:0] status;
  } grant_beat_t;

  // Predicted allocator state.
  logic [255:0]   busy_ids;
  logic [IdW-1:0] recycled [StackDepth];
  int unsigned    recycled_depth;
  int unsigned    fresh_id;

  grant_beat_t    pending_grants [$];
  grant_beat_t    want;
  grant_beat_t    seen;

  assign busy_ids_o = busy_ids;
  assign pending_o  = pending_grants.size();

  function automatic bit id_is_reserved(int unsigned v);
    return (v == 0) || ((v >= RSV_LO) && (v <= RSV_HI));
  endfunction

  function automatic bit id_is_grantable(int unsigned v);
    return !id_is_reserved(v) && (v <= IdLimit);
  endfunction

  function automatic bit id_is_free_and_grantable(int unsigned v);
    return id_is_grantable(v) && !busy_ids[v[7:0]];
  endfunction

  // Updates the predicted state for one input beat and returns its result.
  function automatic grant_beat_t predict_grant(logic cmd, logic [IdW-1:0] id);
    grant_beat_t r;
    int unsigned cand;
    bit          found;
    bit          dup;
    r.granted = '0;
    found     = 1'b0;
    cand      = 0;
    if (cmd == CMD_ACQUIRE) begin
      if (id_is_free_and_grantable(id)) begin
        cand  = id;
        found = 1'b1;
      end
      // Stale entries popped on the way are simply dropped.
      while (!found && recycled_depth > 0) begin
        recycled_depth--;
        cand = recycled[recycled_depth];
        if (id_is_free_and_grantable(cand)) found = 1'b1;
      end
      if (!found) begin
        while (fresh_id <= IdLimit && (id_is_reserved(fresh_id) || busy_ids[fresh_id[7:0]]))
          fresh_id++;
        if (fresh_id <= IdLimit) begin
          cand  = fresh_id;
          found = 1'b1;
          fresh_id++;
        end
      end
      if (found) begin
        busy_ids[cand[7:0]] = 1'b1;
        r.granted = cand[7:0];
        r.status  = ST_OK;
        grants_o++;
      end else begin
        r.status = ST_EXHAUSTED;
        exhausted_o++;
      end
    end else if (busy_ids[id]) begin
      busy_ids[id] = 1'b0;
      dup = 1'b0;
      for (int unsigned i = 0; i < recycled_depth; i++)
        if (recycled[i] == id) dup = 1'b1;
      if (id_is_grantable(id) && !dup && recycled_depth < StackDepth) begin
        recycled[recycled_depth] = id;
        recycled_depth++;
      end
      r.status = ST_OK;
    end else begin
      r.status = ST_NOT_IN_USE;
      refused_o++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_ids       = '0;
      recycled_depth = 0;
      fresh_id       = 1;
      pending_grants.delete();
      fail_count_o   = 0;
      grants_o       = 0;
      exhausted_o    = 0;
      refused_o      = 0;
    end else begin
      // The output side goes first: a result can never belong to the beat
      // accepted at the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.granted = m_axis_tdata_i[7:0];
        seen.status  = m_axis_tdata_i[9:8];
        if (pending_grants.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result beat with nothing expected: id %0d status %0d",
                     $realtime, seen.granted, seen.status);
        end else begin
          want = pending_grants.pop_front();
          if (seen.granted !== want.granted || seen.status !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected id %0d status %0d, got id %0d status %0d",
                       $realtime, want.granted, want.status, seen.granted, seen.status);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        pending_grants.insert(pending_grants.size(),
                              predict_grant(s_axis_tuser_i[0], s_axis_tdata_i));
    end
  end

endmodule

[verif/id_allocator_with_recycle_stack_test.sv]
// Testbench top for id_allocator_with_recycle_stack: clock, reset, stimulus
// and verdict. Depends on idalloc_pkg, the allocator RTL and idalloc_grant_checker.
`timescale 1ns / 1ps

module id_allocator_with_recycle_stack_test;
  import idalloc_pkg::*;

  localparam int unsigned MaxId       = MaxIdDefault;
  localparam int unsigned TotalBeats  = 1300;
  localparam int unsigned HoldCycles  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = CMD_ACQUIRE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int          fail_count;
  int          pending;
  logic [255:0] busy_ids;
  int          grants;
  int          exhausted;
  int          refused;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned holds_done = 0;
  int unsigned beats_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  id_allocator_with_recycle_stack #(
    .MAX_ID (MaxId)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  idalloc_grant_checker #(
    .MAX_ID (MaxId)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .busy_ids_o      (busy_ids),
    .grants_o        (grants),
    .exhausted_o     (exhausted),
    .refused_o       (refused)
  );

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        holds_done++;
      end else begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic cmd, input logic [7:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = id;
    s_tuser  = cmd;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Mostly an id that is currently granted, so releases do real work.
  function automatic logic [7:0] pick_busy_id();
    logic [7:0] v;
    v = 8'($urandom_range(255, 1));
    for (int i = 0; i < 64 && !busy_ids[v]; i++)
      v = 8'($urandom_range(255, 1));
    return v;
  endfunction

  task automatic run_burst();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  id;
    logic        cmd;
    kind = $urandom_range(2);
    len  = $urandom_range(40, 8);
    for (int unsigned n = 0; n < len; n++) begin
      case (kind)
        0: begin
          cmd = CMD_ACQUIRE;
          id  = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
        end
        1: begin
          cmd = CMD_RELEASE;
          id  = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : pick_busy_id();
        end
        default: begin
          cmd = $urandom_range(1) ? CMD_RELEASE : CMD_ACQUIRE;
          id  = $urandom_range(1) ? 8'($urandom_range(255)) : pick_busy_id();
        end
      endcase
      send_beat(cmd, id);
    end
  endtask

  task automatic run_bursts_until(input int unsigned last_beat);
    while (beats_sent < last_beat) run_burst();
  endtask

  initial begin
    int exhausted_before;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 30;
    rx_idle_pct = 62;

    // Preferred id path, reserved and taken preferences, counter path.
    send_beat(CMD_ACQUIRE, 8'd0);
    send_beat(CMD_ACQUIRE, 8'd2);
    send_beat(CMD_ACQUIRE, 8'd3);
    send_beat(CMD_ACQUIRE, 8'd255);
    send_beat(CMD_ACQUIRE, 8'd255);
    send_beat(CMD_ACQUIRE, 8'd128);
    send_beat(CMD_ACQUIRE, 8'd127);
    // Releases of ids that are free, reserved or zero are refused; granted ids are taken back.
    send_beat(CMD_RELEASE, 8'd0);
    send_beat(CMD_RELEASE, 8'd5);
    send_beat(CMD_RELEASE, 8'd200);
    send_beat(CMD_RELEASE, 8'd255);
    send_beat(CMD_RELEASE, 8'd2);
    send_beat(CMD_RELEASE, 8'd2);
    // Recycled ids come back last in, first out.
    send_beat(CMD_ACQUIRE, 8'd0);
    send_beat(CMD_ACQUIRE, 8'd2);
    // A recycled id taken by preference leaves a stale entry on the stack,
    // and a second release of it must not push a duplicate.
    send_beat(CMD_RELEASE, 8'd9);
    send_beat(CMD_ACQUIRE, 8'd9);
    send_beat(CMD_RELEASE, 8'd9);
    send_beat(CMD_ACQUIRE, 8'd9);
    send_beat(CMD_ACQUIRE, 8'd0);
    send_beat(CMD_ACQUIRE, 8'd1);
    send_beat(CMD_RELEASE, 8'd1);
    send_beat(CMD_RELEASE, 8'd10);
    send_beat(CMD_ACQUIRE, 8'd6);

    run_bursts_until(TotalBeats / 3);

    tx_idle_pct = 62;
    rx_idle_pct = 30;
    // Exhaust every source, then keep asking a few more times.
    exhausted_before = exhausted;
    while (exhausted == exhausted_before) send_beat(CMD_ACQUIRE, 8'd0);
    repeat (4) send_beat(CMD_ACQUIRE, 8'($urandom_range(255)));
    run_bursts_until(2 * TotalBeats / 3);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // Long hold-off on the result side while beats keep coming.
    hold_request = 1'b1;
    repeat (20) send_beat($urandom_range(1) ? CMD_RELEASE : CMD_ACQUIRE, pick_busy_id());
    run_bursts_until(TotalBeats);

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);

    $display("Sent %0d beats: %0d grants, %0d exhausted acquires, %0d refused releases.",
             beats_sent, grants, exhausted, refused);
    $display("Idle mixes on both sides and %0d long result hold-off(s) were covered.",
             holds_done);
    if (fail_count == 0) begin
      $display("id_allocator_with_recycle_stack test passed");
    end else begin
      $display("id_allocator_with_recycle_stack test failed");
    end
    $finish;
  end

  // Generous cap: far beyond the slowest legal run of this stimulus.
  initial begin
    #(40_000_000);
    $display("id_allocator_with_recycle_stack test failed");
    $finish;
  end

endmodule
